[hdl/bba_pkg.sv]
// Package for the bitmap block allocator: sizes, request and status codes,
// beat payload types, controller state type and the lowest-clear-bit helper.
// No dependencies.
package bba_pkg;

  // Map geometry
  localparam int BLOCK_BYTES = 4096;
  localparam int MAX_BLOCKS  = 32768;
  localparam int WORD_W      = 32;
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int MAP_WORDS   = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int IDX_W       = $clog2(MAP_WORDS);
  localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);   // block size is a power of two
  localparam int ADDR_W      = 32;
  localparam int BLK_W       = ADDR_W - BLK_SHIFT;
  localparam int CNT_W       = 16;
  localparam int LIVE_W      = $clog2(MAX_BLOCKS + 1);

  localparam logic [WORD_W-1:0] FULL_WORD = '1;

  // Request codes
  localparam logic [1:0] REQ_FREE  = 2'd0;
  localparam logic [1:0] REQ_USED  = 2'd1;
  localparam logic [1:0] REQ_ALLOC = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_IGNORED = 2'd1;
  localparam logic [1:0] STAT_NO_MEM  = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] byte_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    logic [1:0]        status;
  } out_item_t;

  // Memory access group from controller to map RAM
  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
  } mem_req_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_MARK,
    S_SCAN,
    S_FIN
  } state_t;

  // Position of the lowest clear bit; isolate it as a one-hot, then encode
  function automatic logic [BIT_W-1:0] low_clear(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] inv;
    logic [WORD_W-1:0] hot;
    logic [BIT_W-1:0]  pos;
    inv = ~w;
    hot = inv & (~inv + WORD_W'(1));
    pos = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (hot[i]) pos = pos | BIT_W'(i);
    end
    return pos;
  endfunction

endpackage

[hdl/bba_ram.sv]
// Generic single-clock RAM, one write port and one read port, registered read.
// Read data holds while no read is issued. No dependencies.
module bba_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/bba_ctrl.sv]
// Allocator controller: map fill after reset, mark read-modify-write,
// first-fit word scan, result register and block_count register.
// Depends on bba_pkg; drives the map RAM through a bba_pkg::mem_req_t.
module bba_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bba_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bba_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bba_pkg::CNT_W-1:0]      cfg_data,
  output bba_pkg::mem_req_t              mem,
  input  logic [bba_pkg::WORD_W-1:0]     rd_data
);

  bba_pkg::state_t state_r, state_nxt;
  logic [bba_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [bba_pkg::BIT_W-1:0]  bit_r, bit_nxt;
  logic                       set_r, set_nxt;
  logic [1:0]                 pstat_r, pstat_nxt;
  logic [bba_pkg::ADDR_W-1:0] paddr_r, paddr_nxt;
  logic                       out_valid_r, out_valid_nxt;
  bba_pkg::out_item_t         out_data_r, out_data_nxt;
  logic [bba_pkg::CNT_W-1:0]  count_r, count_nxt;

  logic [bba_pkg::LIVE_W-1:0]  live;
  logic [bba_pkg::LIVE_W:0]    words_sum;
  logic [bba_pkg::IDX_W:0]     words;
  logic                        in_fire;
  logic                        slot_free;
  logic [bba_pkg::BLK_W-1:0]   in_blk;
  logic                        in_aligned;
  logic                        in_range;
  logic                        mark_ok;
  logic                        is_alloc;
  logic [bba_pkg::IDX_W-1:0]   in_word;
  logic [bba_pkg::BIT_W-1:0]   in_bit;
  logic                        word_open;
  logic                        last_word;
  logic [bba_pkg::BIT_W-1:0]   free_bit;
  logic [bba_pkg::IDX_W+bba_pkg::BIT_W-1:0] found_blk;
  logic                        found_over;
  logic [bba_pkg::WORD_W-1:0]  bit_hot;
  logic [bba_pkg::WORD_W-1:0]  free_hot;

  // Effective count and number of words it spans
  assign live = (32'(count_r) > 32'(bba_pkg::MAX_BLOCKS)) ?
                bba_pkg::LIVE_W'(bba_pkg::MAX_BLOCKS) : bba_pkg::LIVE_W'(count_r);
  assign words_sum = {1'b0, live} + (bba_pkg::LIVE_W+1)'(bba_pkg::WORD_W - 1);
  assign words     = words_sum[bba_pkg::BIT_W +: bba_pkg::IDX_W+1];

  // Handshakes
  assign in_ready  = (state_r == bba_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Decode an incoming mark
  assign in_blk     = in_data.byte_address[bba_pkg::ADDR_W-1:bba_pkg::BLK_SHIFT];
  assign in_aligned = (in_data.byte_address[bba_pkg::BLK_SHIFT-1:0] == '0);
  assign in_range   = (32'(in_blk) < 32'(live));
  assign mark_ok    = (in_data.req_type inside {bba_pkg::REQ_FREE, bba_pkg::REQ_USED}) &&
                      in_aligned && in_range;
  assign is_alloc   = (in_data.req_type == bba_pkg::REQ_ALLOC);
  assign in_word    = in_blk[bba_pkg::BIT_W +: bba_pkg::IDX_W];
  assign in_bit     = in_blk[bba_pkg::BIT_W-1:0];

  // Scan step on the word just read
  assign word_open  = (rd_data != bba_pkg::FULL_WORD);
  assign last_word  = (({1'b0, idx_r} + (bba_pkg::IDX_W+1)'(1)) == words);
  assign free_bit   = bba_pkg::low_clear(rd_data);
  assign found_blk  = {idx_r, free_bit};
  assign found_over = (32'(found_blk) >= 32'(live));
  assign bit_hot    = bba_pkg::WORD_W'(1) << bit_r;
  assign free_hot   = bba_pkg::WORD_W'(1) << free_bit;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bba_pkg::S_INIT: begin
        if (idx_r == bba_pkg::IDX_W'(bba_pkg::MAP_WORDS - 1)) state_nxt = bba_pkg::S_IDLE;
      end
      bba_pkg::S_IDLE: begin
        if (in_fire) begin
          if (mark_ok) state_nxt = bba_pkg::S_MARK;
          else if (is_alloc && words != '0) state_nxt = bba_pkg::S_SCAN;
          else state_nxt = bba_pkg::S_FIN;
        end
      end
      bba_pkg::S_MARK: begin
        state_nxt = bba_pkg::S_FIN;
      end
      bba_pkg::S_SCAN: begin
        if (word_open || last_word) state_nxt = bba_pkg::S_FIN;
      end
      bba_pkg::S_FIN: begin
        if (slot_free) state_nxt = bba_pkg::S_IDLE;
      end
      default: state_nxt = bba_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory access and result load
  always_comb begin
    mem           = '0;
    idx_nxt       = idx_r;
    bit_nxt       = bit_r;
    set_nxt       = set_r;
    pstat_nxt     = pstat_r;
    paddr_nxt     = paddr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    count_nxt     = (cfg_valid && cfg_ready) ? cfg_data : count_r;
    case (state_r)
      bba_pkg::S_INIT: begin
        mem.wr_en   = 1'b1;
        mem.wr_addr = idx_r;
        mem.wr_data = bba_pkg::FULL_WORD;
        idx_nxt     = idx_r + bba_pkg::IDX_W'(1);
      end
      bba_pkg::S_IDLE: begin
        if (in_fire) begin
          paddr_nxt = '0;
          if (mark_ok) begin
            mem.rd_en   = 1'b1;
            mem.rd_addr = in_word;
            idx_nxt     = in_word;
            bit_nxt     = in_bit;
            set_nxt     = (in_data.req_type == bba_pkg::REQ_USED);
            pstat_nxt   = bba_pkg::STAT_DONE;
          end else if (is_alloc) begin
            // no-memory stands if the count spans no word
            mem.rd_en   = 1'b1;
            mem.rd_addr = '0;
            idx_nxt     = '0;
            pstat_nxt   = bba_pkg::STAT_NO_MEM;
          end else begin
            pstat_nxt   = bba_pkg::STAT_IGNORED;
          end
        end
      end
      bba_pkg::S_MARK: begin
        mem.wr_en   = 1'b1;
        mem.wr_addr = idx_r;
        mem.wr_data = set_r ? (rd_data | bit_hot) : (rd_data & ~bit_hot);
      end
      bba_pkg::S_SCAN: begin
        if (word_open) begin
          if (found_over) begin
            pstat_nxt = bba_pkg::STAT_NO_MEM;
          end else begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = idx_r;
            mem.wr_data = rd_data | free_hot;
            pstat_nxt   = bba_pkg::STAT_DONE;
            paddr_nxt   = bba_pkg::ADDR_W'(found_blk) << bba_pkg::BLK_SHIFT;
          end
        end else if (last_word) begin
          pstat_nxt = bba_pkg::STAT_NO_MEM;
        end else begin
          // advance to the next word
          mem.rd_en   = 1'b1;
          mem.rd_addr = idx_r + bba_pkg::IDX_W'(1);
          idx_nxt     = idx_r + bba_pkg::IDX_W'(1);
        end
      end
      bba_pkg::S_FIN: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.block_address = paddr_r;
          out_data_nxt.status        = pstat_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bba_pkg::S_INIT;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      count_r     <= bba_pkg::CNT_W'(32768);
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    bit_r      <= bit_nxt;
    set_r      <= set_nxt;
    pstat_r    <= pstat_nxt;
    paddr_r    <= paddr_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[hdl/bitmap_block_allocator_core.sv]
// Bitmap block allocator, first fit: 1024 x 32 used map in one RAM.
// Ignored requests go straight to the result, a mark reads and rewrites its word,
// an allocate reads words in turn (one word per cycle, up to 1024).
// One request in flight; the next is taken once the result is registered.
// Reset (rst_n low, synchronous): a fill then sets all 1024 map words to
// all ones with in_ready low; cfg writes are taken throughout.
module bitmap_block_allocator_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bba_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bba_pkg::out_item_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bba_pkg::CNT_W-1:0]  cfg_data
);

  bba_pkg::mem_req_t             mem;
  logic [bba_pkg::WORD_W-1:0]    rd_data;

  // Controller
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .mem       (mem),
    .rd_data   (rd_data)
  );

  // Used map storage
  bba_ram #(
    .DEPTH (bba_pkg::MAP_WORDS),
    .WIDTH (bba_pkg::WORD_W)
  ) u_map (
    .clk     (clk),
    .rd_en   (mem.rd_en),
    .rd_addr (mem.rd_addr),
    .rd_data (rd_data),
    .wr_en   (mem.wr_en),
    .wr_addr (mem.wr_addr),
    .wr_data (mem.wr_data)
  );

endmodule

[hdl/bba_checker.sv]
// Port-level checker for bitmap_block_allocator_core, bound to the top level.
// Depends on bba_pkg for the payload type and status codes.
module bba_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input bba_pkg::out_item_t out_data
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // One request at a time: input closes right after a beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  // Only a successful allocation carries an address
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != bba_pkg::STAT_DONE |-> out_data.block_address == '0)
    else $error("nonzero address on a failed request");

  // Returned addresses are block aligned and statuses are defined codes
  a_addr_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.block_address[bba_pkg::BLK_SHIFT-1:0] == '0 &&
                  out_data.status != 2'd3)
    else $error("misaligned address or undefined status");

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[test/tb.sv]
// Self-checking bench for bitmap_block_allocator_core: a first-fit map tracker
// predicts every reply; directed corner cases, then randomized phases.
// Depends on bba_pkg (hdl/bba_pkg.sv) and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Unused request code, answered as ignored
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam logic [bba_pkg::ADDR_W-1:0] LAST_BLOCK_ADDR =
    bba_pkg::ADDR_W'((bba_pkg::MAX_BLOCKS - 1) * bba_pkg::BLOCK_BYTES);
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned HOLD_OFF = 400;

  // Mirror of the used map; owes one reply per accepted request
  class map_tracker_t;
    logic [bba_pkg::WORD_W-1:0] used_map [bba_pkg::MAP_WORDS];
    logic [bba_pkg::CNT_W-1:0]  block_count;
    bba_pkg::out_item_t         owed_replies[$];
    int                         failures;

    function new();
      foreach (used_map[i]) used_map[i] = bba_pkg::FULL_WORD;
      block_count = bba_pkg::CNT_W'(bba_pkg::MAX_BLOCKS);
      failures = 0;
    endfunction

    function int unsigned live_blocks();
      return (block_count > bba_pkg::MAX_BLOCKS) ? bba_pkg::MAX_BLOCKS : block_count;
    endfunction

    // Set or clear one block's bit; bad addresses leave the map alone
    function logic [1:0] mark_block(input logic [bba_pkg::ADDR_W-1:0] addr, input bit set);
      longint unsigned a;
      longint unsigned blk;
      a = addr;
      if ((a % bba_pkg::BLOCK_BYTES) != 0) return bba_pkg::STAT_IGNORED;
      blk = a / bba_pkg::BLOCK_BYTES;
      if (blk >= live_blocks()) return bba_pkg::STAT_IGNORED;
      used_map[blk >> 5][blk & 31] = set;
      return bba_pkg::STAT_DONE;
    endfunction

    // First fit: skip full words, take lowest clear bit below the count
    function logic [1:0] take_first_free(output logic [bba_pkg::ADDR_W-1:0] addr);
      int unsigned cnt;
      int unsigned words;
      int unsigned blk;
      cnt = live_blocks();
      words = (cnt + 31) / 32;
      if (words > bba_pkg::MAP_WORDS) words = bba_pkg::MAP_WORDS;
      addr = '0;
      for (int unsigned i = 0; i < words; i++) begin
        if (used_map[i] == bba_pkg::FULL_WORD) continue;
        for (int unsigned j = 0; j < 32; j++) begin
          blk = i * 32 + j;
          if (blk >= cnt) return bba_pkg::STAT_NO_MEM;
          if (!used_map[i][j]) begin
            used_map[i][j] = 1'b1;
            addr = bba_pkg::ADDR_W'(longint'(blk) * bba_pkg::BLOCK_BYTES);
            return bba_pkg::STAT_DONE;
          end
        end
      end
      return bba_pkg::STAT_NO_MEM;
    endfunction

    function void note_request(input bba_pkg::in_item_t req);
      bba_pkg::out_item_t reply;
      reply.block_address = '0;
      case (req.req_type)
        bba_pkg::REQ_FREE:  reply.status = mark_block(req.byte_address, 1'b0);
        bba_pkg::REQ_USED:  reply.status = mark_block(req.byte_address, 1'b1);
        bba_pkg::REQ_ALLOC: reply.status = take_first_free(reply.block_address);
        default:            reply.status = bba_pkg::STAT_IGNORED;
      endcase
      owed_replies.push_back(reply);
    endfunction

    function void check_reply(input bba_pkg::out_item_t got);
      bba_pkg::out_item_t want;
      if (owed_replies.size() == 0) begin
        $error("unexpected reply: block_address %h status %0d", got.block_address, got.status);
        failures++;
        return;
      end
      want = owed_replies.pop_front();
      if (got.block_address !== want.block_address) begin
        $error("block_address: expected %h, got %h", want.block_address, got.block_address);
        failures++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        failures++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  bba_pkg::in_item_t         in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  bba_pkg::out_item_t        out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [bba_pkg::CNT_W-1:0] cfg_data = '0;

  map_tracker_t tracker = new();
  int unsigned  idle_pct = 18;
  int unsigned  hold_cycles = 0;
  int unsigned  cycle_count = 0;
  int unsigned  live_now = bba_pkg::MAX_BLOCKS;

  bitmap_block_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Count cycles for the watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watch both channels for accepted beats
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) tracker.note_request(in_data);
    if (rst_n && out_valid && out_ready) tracker.check_reply(out_data);
  end

  // Receiver: random stalls, or a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Abort a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb: errors");
    $finish;
  end

  // Offer one request beat, idling at random first; hold it until taken
  task automatic send_item(input bba_pkg::in_item_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_req(input logic [1:0] req, input logic [bba_pkg::ADDR_W-1:0] addr);
    bba_pkg::in_item_t item;
    item.req_type = req;
    item.byte_address = addr;
    send_item(item);
  endtask

  // Drain every reply, settle, then write block_count
  task automatic retune(input logic [bba_pkg::CNT_W-1:0] count);
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.owed_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.block_count = count;
    live_now = tracker.live_blocks();
    @(posedge clk);
  endtask

  // Mostly well-formed marks and allocations near the live range, some noise
  function automatic bba_pkg::in_item_t random_req(input int unsigned live);
    bba_pkg::in_item_t item;
    int unsigned       pick;
    int unsigned       span;
    int unsigned       blk;
    pick = $urandom_range(99);
    span = (live > 512) ? 512 : live;
    blk = $urandom_range(span + 8, 0);
    item.byte_address = bba_pkg::ADDR_W'(blk) << bba_pkg::BLK_SHIFT;
    if (pick < 35) begin
      item.req_type = bba_pkg::REQ_ALLOC;
      item.byte_address = $urandom;
    end else if (pick < 70) begin
      item.req_type = bba_pkg::REQ_FREE;
    end else if (pick < 85) begin
      item.req_type = bba_pkg::REQ_USED;
    end else if (pick < 90) begin
      item.req_type = $urandom_range(1) ? bba_pkg::REQ_USED : bba_pkg::REQ_FREE;
      item.byte_address = item.byte_address |
                          bba_pkg::ADDR_W'($urandom_range(bba_pkg::BLOCK_BYTES - 1, 1));
    end else if (pick < 95) begin
      item.req_type = $urandom_range(1) ? bba_pkg::REQ_USED : bba_pkg::REQ_FREE;
      item.byte_address = $urandom;
    end else begin
      item.req_type = REQ_SPARE;
      item.byte_address = $urandom;
    end
    return item;
  endfunction

  initial begin
    int unsigned               total;
    int unsigned               phase;
    int unsigned               n;
    int unsigned               sel;
    logic [bba_pkg::CNT_W-1:0] count;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: full map at reset count, re-marks, bad marks, last block
    send_req(bba_pkg::REQ_ALLOC, 32'h0000_0000);
    send_req(REQ_SPARE, 32'h5A5A_A5A5);
    send_req(bba_pkg::REQ_FREE, 32'h0000_0000);
    send_req(bba_pkg::REQ_FREE, 32'h0000_0000);
    send_req(bba_pkg::REQ_ALLOC, 32'hFFFF_FFFF);
    send_req(bba_pkg::REQ_USED, 32'h0000_0000);
    send_req(bba_pkg::REQ_FREE, 32'h0000_0001);
    send_req(bba_pkg::REQ_FREE, 32'hFFFF_F000);
    send_req(bba_pkg::REQ_USED, 32'hFFFF_FFFF);
    send_req(bba_pkg::REQ_FREE, LAST_BLOCK_ADDR);
    send_req(bba_pkg::REQ_FREE, LAST_BLOCK_ADDR + bba_pkg::BLOCK_BYTES);
    send_req(bba_pkg::REQ_ALLOC, 32'h0000_0000);
    send_req(bba_pkg::REQ_FREE, 32'h0000_1000);
    send_req(bba_pkg::REQ_ALLOC, 32'h0000_0000);

    // Count above capacity acts as full capacity
    retune('1);
    send_req(bba_pkg::REQ_FREE, LAST_BLOCK_ADDR);
    send_req(bba_pkg::REQ_USED, LAST_BLOCK_ADDR + bba_pkg::BLOCK_BYTES);
    send_req(bba_pkg::REQ_ALLOC, 32'h0000_0000);

    // Zero count: nothing in range, nothing to allocate
    retune('0);
    send_req(bba_pkg::REQ_FREE, 32'h0000_0000);
    send_req(bba_pkg::REQ_ALLOC, 32'h0000_0000);

    // Single block: exhaust it
    retune(bba_pkg::CNT_W'(1));
    send_req(bba_pkg::REQ_FREE, 32'h0000_0000);
    send_req(bba_pkg::REQ_FREE, 32'h0000_1000);
    send_req(bba_pkg::REQ_ALLOC, 32'h0000_0000);
    send_req(bba_pkg::REQ_ALLOC, 32'h0000_0000);

    retune(bba_pkg::CNT_W'(bba_pkg::MAX_BLOCKS));
    send_req(bba_pkg::REQ_ALLOC, 32'h0000_0000);
    total = 24;

    // Random phases, each with its own count; mostly small maps
    phase = 0;
    while (total < 1950) begin
      sel = $urandom_range(9);
      case (sel)
        0:       count = '0;
        1:       count = bba_pkg::CNT_W'(1);
        2:       count = bba_pkg::CNT_W'(31);
        3:       count = bba_pkg::CNT_W'(32);
        4:       count = bba_pkg::CNT_W'(33);
        9:       count = $urandom_range(1) ? bba_pkg::CNT_W'(bba_pkg::MAX_BLOCKS) :
                                             bba_pkg::CNT_W'($urandom);
        default: count = bba_pkg::CNT_W'($urandom_range(512, 2));
      endcase
      retune(count);
      n = (live_now > 512) ? 15 : $urandom_range(120, 40);
      idle_pct = 18;
      if (phase == 2) begin
        idle_pct = 0;
        n = 200;
      end
      // Stall the reply side long enough to back up the request side
      if (phase == 3) hold_cycles = HOLD_OFF;
      for (int unsigned k = 0; k < n; k++) send_item(random_req(live_now));
      total += n;
      phase++;
    end

    // Drain and report
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.owed_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.failures == 0 && tracker.owed_replies.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
